[design/hebin_pkg.sv]
// ----------------------------------------------------------------------------
// hebin_pkg: shared types and constants for the edge-based histogram
// Sizes of the edge and count stores, action codes and sequencer states.
// ----------------------------------------------------------------------------
package hebin_pkg;

  localparam int MAX_BINS     = 64;
  localparam int EDGE_DEPTH   = MAX_BINS + 1;
  localparam int EDGE_AW      = $clog2(EDGE_DEPTH);
  localparam int BIN_AW       = $clog2(MAX_BINS);
  localparam int SAMPLE_WIDTH = 32;
  localparam int COUNT_WIDTH  = 32;
  localparam int SLOT_W       = 7;
  localparam int ACTION_W     = 2;
  localparam int CFG_W        = 7;
  localparam int NUM_BINS_RST = 64;

  typedef enum logic [ACTION_W-1:0] {
    ACT_WRITE_EDGE = 2'd0,
    ACT_BIN_SAMPLE = 2'd1,
    ACT_READ_COUNT = 2'd2,
    ACT_CLEAR      = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TOP,
    ST_SCAN,
    ST_COUNT,
    ST_READ
  } state_t;

endpackage

[design/hebin_if.sv]
// ----------------------------------------------------------------------------
// hebin_if: valid/ready channels of the edge-based histogram
// One interface for the action beats and one for the result beats.
// ----------------------------------------------------------------------------
interface hebin_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [hebin_pkg::ACTION_W-1:0]       action;
  logic [hebin_pkg::SLOT_W-1:0]         slot;
  logic signed [hebin_pkg::SAMPLE_WIDTH-1:0] value;

  modport source (output valid, output action, output slot, output value, input ready);
  modport sink   (input valid, input action, input slot, input value, output ready);
endinterface

interface hebin_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [hebin_pkg::SLOT_W-1:0]         bin_number;
  logic [hebin_pkg::COUNT_WIDTH-1:0]    count_value;

  modport source (output valid, output bin_number, output count_value, input ready);
  modport sink   (input valid, input bin_number, input count_value, output ready);
endinterface

[design/histogram_edge_binning.sv]
// ----------------------------------------------------------------------------
// histogram_edge_binning: edge-based histogram counter
// Bins signed samples against host-loaded ascending edges, keeps saturating
// per-bin counts in a RAM and answers count reads.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries action beats (write edge, bin sample, read count, clear);
//   out_ch returns one result beat per action: bin_number for a sample,
//   count_value for a read, zeros otherwise. cfg_wr_en/cfg_wr_data load
//   num_bins; the user must do so while the block is idle (not enforced).
// Sequencing (one action in flight at a time):
//   edge write, clear, read of a slot beyond the bins: result registered in
//   the cycle after acceptance; count read: through ST_READ; sample: ST_TOP
//   for the top-edge check, then ST_SCAN for each edge visited by the
//   downward scan (at most num_bins), then ST_COUNT for the saturating
//   read-modify-write; the edge RAM's single read port serialises the scan.
// Reset: num_bins returns to 64 and all counts read as zero through per-bin
//   valid flags; edges are undefined until written. No clearing pass.
// Stall: a finished result waits in the output register; the next action is
//   taken in the cycle the result is taken or any cycle after.
// ----------------------------------------------------------------------------
module histogram_edge_binning (
  input  logic                        clk,
  input  logic                        rst_n,
  hebin_in_if.sink                    in_ch,
  hebin_out_if.source                 out_ch,
  input  logic                        cfg_wr_en,
  input  logic [hebin_pkg::CFG_W-1:0] cfg_wr_data
);
  import hebin_pkg::*;

  state_t                          state_r, state_nxt;
  logic [CFG_W-1:0]                num_bins_r;
  logic [BIN_AW-1:0]               idx_r, idx_nxt;
  logic signed [SAMPLE_WIDTH-1:0]  key_r, key_nxt;
  logic [MAX_BINS-1:0]             valid_r, valid_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [SLOT_W-1:0]               out_bin_r, out_bin_nxt;
  logic [COUNT_WIDTH-1:0]          out_count_r, out_count_nxt;

  logic [EDGE_AW-1:0]              nb_use;
  logic                            accept;
  action_t                         in_action;

  logic                            edge_we;
  logic [EDGE_AW-1:0]              edge_waddr, edge_raddr;
  logic [SAMPLE_WIDTH-1:0]         edge_wdata, edge_rdata;
  logic signed [SAMPLE_WIDTH-1:0]  edge_val;

  logic                            cnt_we;
  logic [BIN_AW-1:0]               cnt_raddr;
  logic [COUNT_WIDTH-1:0]          cnt_wdata, cnt_rdata, cnt_cur;

  // edge store
  hebin_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(EDGE_DEPTH)) u_edge_ram (
    .clk   (clk),
    .we    (edge_we),
    .waddr (edge_waddr),
    .wdata (edge_wdata),
    .raddr (edge_raddr),
    .rdata (edge_rdata)
  );

  // count store
  hebin_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(MAX_BINS)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (idx_r),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  // clamp the bin count to the legal range
  always_comb begin
    if (num_bins_r == '0) begin
      nb_use = EDGE_AW'(1);
    end else if (EDGE_AW'(num_bins_r) > EDGE_AW'(MAX_BINS)) begin
      nb_use = EDGE_AW'(MAX_BINS);
    end else begin
      nb_use = EDGE_AW'(num_bins_r);
    end
  end

  assign in_ch.ready = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;
  assign in_action   = action_t'(in_ch.action);
  assign edge_val    = $signed(edge_rdata);
  assign cnt_cur     = valid_r[idx_r] ? cnt_rdata : '0;

  // sequencer: next state, RAM control and result load
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    key_nxt       = key_r;
    valid_nxt     = valid_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_bin_nxt   = out_bin_r;
    out_count_nxt = out_count_r;
    edge_we       = 1'b0;
    edge_waddr    = EDGE_AW'(in_ch.slot);
    edge_wdata    = in_ch.value;
    edge_raddr    = nb_use;
    cnt_we        = 1'b0;
    cnt_raddr     = idx_r;
    cnt_wdata     = (cnt_cur == '1) ? cnt_cur : cnt_cur + COUNT_WIDTH'(1);

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_bin_nxt   = '0;
          out_count_nxt = '0;
          case (in_action)
            ACT_WRITE_EDGE: begin
              edge_we       = (in_ch.slot <= SLOT_W'(MAX_BINS));
              out_valid_nxt = 1'b1;
            end
            ACT_BIN_SAMPLE: begin
              key_nxt   = in_ch.value;
              state_nxt = ST_TOP;
            end
            ACT_READ_COUNT: begin
              if (in_ch.slot < SLOT_W'(MAX_BINS)) begin
                cnt_raddr = in_ch.slot[BIN_AW-1:0];
                idx_nxt   = in_ch.slot[BIN_AW-1:0];
                state_nxt = ST_READ;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            ACT_CLEAR: begin
              valid_nxt     = '0;
              out_valid_nxt = 1'b1;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      // top edge closes the last bin on the right
      ST_TOP: begin
        if (key_r > edge_val) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          idx_nxt    = BIN_AW'(nb_use - EDGE_AW'(1));
          edge_raddr = nb_use - EDGE_AW'(1);
          state_nxt  = ST_SCAN;
        end
      end
      // walk down the lower edges until one is at or below the sample
      ST_SCAN: begin
        if (edge_val <= key_r) begin
          cnt_raddr = idx_r;
          state_nxt = ST_COUNT;
        end else if (idx_r == '0) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          idx_nxt    = idx_r - BIN_AW'(1);
          edge_raddr = EDGE_AW'(idx_r - BIN_AW'(1));
        end
      end
      // saturating increment and write back
      ST_COUNT: begin
        cnt_we           = 1'b1;
        valid_nxt[idx_r] = 1'b1;
        out_valid_nxt    = 1'b1;
        out_bin_nxt      = SLOT_W'(idx_r) + SLOT_W'(1);
        state_nxt        = ST_IDLE;
      end
      ST_READ: begin
        out_valid_nxt = 1'b1;
        out_count_nxt = cnt_cur;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      num_bins_r  <= CFG_W'(NUM_BINS_RST);
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        num_bins_r <= cfg_wr_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    key_r       <= key_nxt;
    out_bin_r   <= out_bin_nxt;
    out_count_r <= out_count_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.bin_number  = out_bin_r;
  assign out_ch.count_value = out_count_r;

endmodule

[design/hebin_ram.sv]
// ----------------------------------------------------------------------------
// hebin_ram: simple dual-port synchronous RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module hebin_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
